### src/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants for the terminal line editor
// Command codes, configuration bundle, queue word and byte constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tle_pkg;

    // Line store geometry
    localparam int MAX_LINE = 64;
    localparam int LEN_W    = $clog2(MAX_LINE + 1);
    localparam int ADDR_W   = $clog2(MAX_LINE);

    // Longest echo run produced by one key (word erase with two digits)
    localparam int SEQ_MAX  = 8;
    localparam int SEQ_IW   = $clog2(SEQ_MAX);
    localparam int SEQ_CW   = $clog2(SEQ_MAX + 1);

    // Configuration port
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        REG_ERASE  = 3'd0,
        REG_KILL   = 3'd1,
        REG_WERASE = 3'd2,
        REG_END    = 3'd3,
        REG_WIDTH  = 3'd4
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [7:0]       ERASE_RST  = 8'd127;
    localparam logic [7:0]       KILL_RST   = 8'd21;
    localparam logic [7:0]       WERASE_RST = 8'd23;
    localparam logic [7:0]       END_RST    = 8'd4;
    localparam logic [LEN_W-1:0] WIDTH_RST  = LEN_W'(40);

    // Byte constants
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Key classes decided by the front end
    typedef enum logic [2:0] {
        CMD_PRINT  = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_KILL   = 3'd2,
        CMD_WERASE = 3'd3,
        CMD_END    = 3'd4,
        CMD_BELL   = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0]       erase_char;
        logic [7:0]       kill_char;
        logic [7:0]       word_erase_char;
        logic [7:0]       end_char;
        logic [LEN_W-1:0] line_width;
    } cfg_t;

endpackage

### src/tle_cfg.sv
// ----------------------------------------------------------------------------
// tle_cfg: configuration register file
// APB-style write/read access to the editing codes and the line width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tle_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tle_pkg::PADDR_W-1:0]  paddr,
    input  logic [tle_pkg::PDATA_W-1:0]  pwdata,
    output logic [tle_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tle_pkg::cfg_t                cfg
);
    import tle_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.erase_char      <= ERASE_RST;
            cfg_reg.kill_char       <= KILL_RST;
            cfg_reg.word_erase_char <= WERASE_RST;
            cfg_reg.end_char        <= END_RST;
            cfg_reg.line_width      <= WIDTH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ERASE:  cfg_reg.erase_char      <= pwdata[7:0];
                REG_KILL:   cfg_reg.kill_char       <= pwdata[7:0];
                REG_WERASE: cfg_reg.word_erase_char <= pwdata[7:0];
                REG_END:    cfg_reg.end_char        <= pwdata[7:0];
                REG_WIDTH:  cfg_reg.line_width      <= pwdata[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_ERASE:  prdata = PDATA_W'(cfg_reg.erase_char);
            REG_KILL:   prdata = PDATA_W'(cfg_reg.kill_char);
            REG_WERASE: prdata = PDATA_W'(cfg_reg.word_erase_char);
            REG_END:    prdata = PDATA_W'(cfg_reg.end_char);
            REG_WIDTH:  prdata = PDATA_W'(cfg_reg.line_width);
            default:    prdata = '0;
        endcase
    end

endmodule

### src/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front: key classifier and command queue
// Sorts each incoming key into a command class and buffers it in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  tle_pkg::cfg_t       cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] key_byte
    output logic                q_valid,
    input  logic                q_pop,
    output tle_pkg::cmd_word_t  q_word
);
    import tle_pkg::*;

    cmd_word_t  q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    cmd_word_t  in_word;

    // Classification: printable text first, then erase, kill, word erase, end
    always_comb
    begin
        in_word.key = s_tdata;
        if (s_tdata >= CH_SPACE && s_tdata <= CH_TILDE)
            in_word.cmd = CMD_PRINT;
        else if (s_tdata == cfg.erase_char)
            in_word.cmd = CMD_ERASE;
        else if (s_tdata == cfg.kill_char)
            in_word.cmd = CMD_KILL;
        else if (s_tdata == cfg.word_erase_char)
            in_word.cmd = CMD_WERASE;
        else if (s_tdata == cfg.end_char)
            in_word.cmd = CMD_END;
        else
            in_word.cmd = CMD_BELL;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_pop & q_valid;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= in_word;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

### src/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back: line store and command execution
// Holds the line in a 64-byte store, scans it for word erase, builds the
// echo run for each command and streams it out through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tle_pkg::cfg_t       cfg,
    input  logic                q_valid,
    output logic                q_pop,
    input  tle_pkg::cmd_word_t  q_word,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] echo_byte
    output logic                m_tlast,    // last_of_run
    output logic                m_tuser     // [0] quit
);
    import tle_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Split a count of at most 64 into tens and ones; v*13/128 gives v/10 here
    function automatic logic [7:0] dec_split(input logic [LEN_W-1:0] v);
        logic [10:0]      prod;
        logic [3:0]       tens;
        logic [LEN_W-1:0] ones;
        prod = 11'(v) * 11'd13;
        tens = prod[10:7];
        ones = v - LEN_W'({tens, 3'b000} + {tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

    state_t           state_reg, state_next;
    cmd_word_t        cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] issue_reg, issue_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic             prev_space_reg, prev_space_next;
    logic [LEN_W-1:0] start_reg, start_next;
    logic [7:0]       seq_reg [SEQ_MAX];
    logic [7:0]       seq_next [SEQ_MAX];
    logic [SEQ_CW-1:0] cnt_reg, cnt_next;
    logic [SEQ_IW-1:0] idx_reg, idx_next;
    logic             quit_reg, quit_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_user_reg, out_user_next;

    // Line store
    logic [7:0]        mem [MAX_LINE];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;

    logic [LEN_W-1:0]  width_eff;
    logic [LEN_W-1:0]  erased;
    logic [7:0]        digits;
    logic              is_space;
    logic              out_free;
    logic              run_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // Width clamped to 1..MAX_LINE
    always_comb
    begin
        if (cfg.line_width == '0)
            width_eff = LEN_W'(1);
        else if (cfg.line_width > LEN_W'(MAX_LINE))
            width_eff = LEN_W'(MAX_LINE);
        else
            width_eff = cfg.line_width;
    end

    assign erased   = len_reg - start_reg;
    assign digits   = dec_split(erased);
    assign is_space = (rd_data_reg == CH_SPACE);
    assign out_free = !out_valid_reg || m_tready;
    assign run_last = ({1'b0, idx_reg} == SEQ_CW'(cnt_reg - SEQ_CW'(1)));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= cmd_reg.key;
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        prev_space_next = prev_space_reg;
        start_next      = start_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        quit_next       = quit_reg;
        for (int i = 0; i < SEQ_MAX; i++)
            seq_next[i] = seq_reg[i];
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_user_next   = out_user_reg;
        q_pop           = 1'b0;
        rd_addr         = issue_reg[ADDR_W-1:0];
        mem_we          = 1'b0;
        wr_addr         = len_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                issue_next      = '0;
                prev_space_next = 1'b1;
                start_next      = '0;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_word;
                    state_next = (q_word.cmd == CMD_WERASE) ? ST_SCAN : ST_LOAD;
                end
            end

            // Read one entry per cycle; its data returns in the next cycle
            ST_SCAN:
            begin
                if (issue_reg < len_reg)
                begin
                    issue_next      = issue_reg + LEN_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[ADDR_W-1:0];
                end
                if (pend_valid_reg)
                begin
                    if (!is_space && prev_space_reg)
                        start_next = LEN_W'(pend_idx_reg);
                    prev_space_next = is_space;
                end
                if (issue_reg == len_reg && !pend_valid_reg)
                    state_next = ST_LOAD;
            end

            // Carry out the command and build its echo run
            ST_LOAD:
            begin
                quit_next = 1'b0;
                cnt_next  = '0;
                idx_next  = '0;
                case (cmd_reg.cmd)
                    CMD_PRINT:
                    begin
                        mem_we = 1'b1;
                        if (len_reg >= width_eff)
                        begin
                            wr_addr     = '0;
                            len_next    = LEN_W'(1);
                            seq_next[0] = CH_LF;
                            seq_next[1] = cmd_reg.key;
                            cnt_next    = SEQ_CW'(2);
                        end
                        else
                        begin
                            len_next    = len_reg + LEN_W'(1);
                            seq_next[0] = cmd_reg.key;
                            cnt_next    = SEQ_CW'(1);
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (len_reg != '0)
                        begin
                            len_next    = len_reg - LEN_W'(1);
                            seq_next[0] = CH_ESC;
                            seq_next[1] = CH_LBRK;
                            seq_next[2] = CH_D;
                            seq_next[3] = CH_ESC;
                            seq_next[4] = CH_LBRK;
                            seq_next[5] = CH_K;
                            cnt_next    = SEQ_CW'(6);
                        end
                    end
                    CMD_KILL:
                    begin
                        len_next    = '0;
                        seq_next[0] = CH_ESC;
                        seq_next[1] = CH_LBRK;
                        seq_next[2] = CH_2;
                        seq_next[3] = CH_K;
                        seq_next[4] = CH_CR;
                        cnt_next    = SEQ_CW'(5);
                    end
                    CMD_WERASE:
                    begin
                        len_next    = start_reg;
                        seq_next[0] = CH_ESC;
                        seq_next[1] = CH_LBRK;
                        if (digits[7:4] != 4'd0)
                        begin
                            seq_next[2] = CH_0 + {4'd0, digits[7:4]};
                            seq_next[3] = CH_0 + {4'd0, digits[3:0]};
                            seq_next[4] = CH_D;
                            seq_next[5] = CH_ESC;
                            seq_next[6] = CH_LBRK;
                            seq_next[7] = CH_K;
                            cnt_next    = SEQ_CW'(8);
                        end
                        else
                        begin
                            seq_next[2] = CH_0 + {4'd0, digits[3:0]};
                            seq_next[3] = CH_D;
                            seq_next[4] = CH_ESC;
                            seq_next[5] = CH_LBRK;
                            seq_next[6] = CH_K;
                            cnt_next    = SEQ_CW'(7);
                        end
                    end
                    CMD_END:
                    begin
                        if (len_reg == '0)
                        begin
                            seq_next[0] = CH_NUL;
                            quit_next   = 1'b1;
                            cnt_next    = SEQ_CW'(1);
                        end
                    end
                    default:
                    begin
                        seq_next[0] = CH_BEL;
                        cnt_next    = SEQ_CW'(1);
                    end
                endcase
                state_next = (cnt_next == '0) ? ST_IDLE : ST_EMIT;
            end

            // One word per free output slot
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = seq_reg[idx_reg];
                    out_last_next  = run_last;
                    out_user_next  = quit_reg;
                    idx_next       = idx_reg + SEQ_IW'(1);
                    if (run_last)
                        state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        prev_space_reg <= prev_space_next;
        start_reg      <= start_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        quit_reg       <= quit_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_user_reg   <= out_user_next;
        for (int i = 0; i < SEQ_MAX; i++)
            seq_reg[i] <= seq_next[i];
    end

endmodule

### src/terminal_line_editor.sv
// A key is queued by the front end, popped in ST_IDLE and carried out in
// ST_LOAD, which builds its echo run; ST_EMIT registers the words. Word erase
// first scans the line store in ST_SCAN, one entry per cycle. The next key is
// popped only after a run's last word is registered; a run has up to 8 words.
// Reset (rst_n, asynchronous): empty line, queue and output cleared, registers
// at their defaults; the line store itself is not cleared.
// ----------------------------------------------------------------------------
// terminal_line_editor: canonical-mode line editor
// Front end classifies keys into a small queue; back end edits the line and
// streams the echo bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_line_editor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tle_pkg::PADDR_W-1:0]  paddr,
    input  logic [tle_pkg::PDATA_W-1:0]  pwdata,
    output logic [tle_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] key_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] echo_byte
    output logic                         m_tlast,   // last_of_run
    output logic                         m_tuser    // [0] quit
);
    import tle_pkg::*;

    cfg_t      cfg;
    logic      q_valid;
    logic      q_pop;
    cmd_word_t q_word;

    tle_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_word   (q_word)
    );

    tle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_word   (q_word),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
